// ----- rtl/pbr1_pkg.sv -----
// Shared types and constants for the planar ByteRun1 body decoder.
// No dependencies; imported by pbr1_advance and planar_byterun1_decoder.
`default_nettype none

package pbr1_pkg;

    // Default limits for the top-level parameters.
    localparam int MAX_ROW_BYTES_DEF = 128;
    localparam int MAX_ROWS_DEF      = 1024;
    localparam int MAX_PLANES_DEF    = 8;

    // Field widths of the configuration registers.
    localparam int MODE_W = 8;
    localparam int BPR_W  = 8;
    localparam int PLN_W  = 4;
    localparam int ROWS_W = 11;
    localparam int CFG_W  = 11;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_COMPRESSION   = 2'd0,
        CFG_BYTES_PER_ROW = 2'd1,
        CFG_PLANE_COUNT   = 2'd2,
        CFG_ROW_COUNT     = 2'd3
    } cfg_index_t;

    // Compression codes.
    localparam logic [MODE_W-1:0] MODE_RAW      = 8'd0;
    localparam logic [MODE_W-1:0] MODE_BYTERUN1 = 8'd1;

    // The ByteRun1 header that does nothing.
    localparam logic [7:0] HDR_NOP = 8'd128;

    // Register values after reset.
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_BYTERUN1;
    localparam logic [BPR_W-1:0]  BPR_RESET  = 8'd40;
    localparam logic [PLN_W-1:0]  PLN_RESET  = 4'd5;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 11'd256;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LITERAL = 3'd1,
        PH_REPEAT  = 3'd2,
        PH_DONE    = 3'd3,
        PH_FAILED  = 3'd4
    } phase_t;

    // Write position inside the image.
    typedef struct packed {
        logic [BPR_W-1:0]  col;
        logic [PLN_W-1:0]  plane;
        logic [ROWS_W-1:0] row;
    } pos_t;

    // Limits after clamping to the build-time maxima.
    typedef struct packed {
        logic [BPR_W-1:0]  bpr;
        logic [PLN_W-1:0]  planes;
        logic [ROWS_W-1:0] rows;
    } limits_t;

endpackage

`default_nettype wire

// ----- rtl/planar_byterun1_decoder.sv -----
// Top level of the planar ByteRun1 (PackBits) body decoder.
// Depends on pbr1_pkg and pbr1_advance.
`default_nettype none

// Usage overview.
// Bytes of an image body chunk enter on the input channel (in_valid, in_stall,
// data_byte, last_byte), one per beat. Each data byte that lands in the image
// leaves as one beat on the output channel (out_valid, out_stall) carrying
// the byte, its run length and its plane, row and column; header bytes give
// no beat. A malformed stream gives a single beat with error set and all
// other fields zero; after it, or after the beat flagged image_done, every
// byte is taken and dropped until reset.
// An accepted byte sits in the input register, where the header/run logic
// and the position stepper decode it, and its result is loaded into the
// output register once that register is free or being emptied. One byte is
// accepted every cycle while in_stall is low; the only loop is the decode
// state plus row, plane and column counters, which update in the same cycle
// the byte is decoded.
// When the receiver stalls, the output register holds its beat; the input
// register still takes one more byte, and in_stall rises only while both
// registers are full. Reset clears both registers and the decode state and
// loads the configuration defaults (ByteRun1, 40 bytes per row, 5 planes,
// 256 rows). Configuration writes take effect on the next decoded byte.

module planar_byterun1_decoder
    import pbr1_pkg::*;
#(
    parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF,
    parameter int MAX_ROWS      = MAX_ROWS_DEF,
    parameter int MAX_PLANES    = MAX_PLANES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        value,
    output logic [7:0]        run_length,
    output logic [2:0]        plane_index,
    output logic [9:0]        row_index,
    output logic [6:0]        column,
    output logic              image_done,
    output logic              error
);

    // Configuration registers.
    logic [MODE_W-1:0] mode_reg;
    logic [BPR_W-1:0]  bpr_reg;
    logic [PLN_W-1:0]  planes_reg;
    logic [ROWS_W-1:0] rows_reg;

    // Input register.
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_data_reg;
    logic       s1_last_reg;
    logic       in_accept;
    logic       s1_fire;

    // Decode state.
    phase_t     phase_reg, phase_next;
    logic [7:0] lit_reg, lit_next;
    logic [7:0] rep_reg, rep_next;
    pos_t       pos_reg, pos_next;

    // Output register.
    logic       out_valid_reg, out_valid_next;
    logic [7:0] value_reg;
    logic [7:0] len_reg;
    logic [2:0] plane_reg;
    logic [9:0] row_reg;
    logic [6:0] col_reg;
    logic       done_reg;
    logic       err_reg;

    // Decode signals.
    limits_t    lim;
    logic       empty;
    logic [7:0] room;
    logic [7:0] lit_dec;
    logic [7:0] hdr_len;
    logic [7:0] run_len;
    logic       do_run;
    logic       do_err;
    phase_t     phase_pre;
    pos_t       adv_pos;
    logic       adv_done;
    logic       res_valid;
    logic       res_err;
    logic       res_done;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RESET;
            bpr_reg    <= BPR_RESET;
            planes_reg <= PLN_RESET;
            rows_reg   <= ROWS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_COMPRESSION:   mode_reg   <= cfg_data[MODE_W-1:0];
                CFG_BYTES_PER_ROW: bpr_reg    <= cfg_data[BPR_W-1:0];
                CFG_PLANE_COUNT:   planes_reg <= cfg_data[PLN_W-1:0];
                CFG_ROW_COUNT:     rows_reg   <= cfg_data[ROWS_W-1:0];
                default:           mode_reg   <= mode_reg;
            endcase
        end
    end

    // Registers larger than the build limits are clamped to them.
    always_comb
    begin
        lim.bpr    = (32'(bpr_reg) > MAX_ROW_BYTES) ? BPR_W'(MAX_ROW_BYTES) : bpr_reg;
        lim.planes = (32'(planes_reg) > MAX_PLANES) ? PLN_W'(MAX_PLANES) : planes_reg;
        lim.rows   = (32'(rows_reg) > MAX_ROWS) ? ROWS_W'(MAX_ROWS) : rows_reg;
        empty      = (lim.bpr == '0) || (lim.planes == '0) || (lim.rows == '0);
        room       = (pos_reg.col >= lim.bpr) ? 8'd0 : lim.bpr - pos_reg.col;
    end

    // ------------------------------------------------------------------
    // Handshake. The input register moves on whenever the output register
    // is free or being emptied this cycle.
    // ------------------------------------------------------------------
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_fire;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    // ------------------------------------------------------------------
    // Byte decode: picks the action for the byte in the input register and
    // the next run-control state.
    // ------------------------------------------------------------------
    assign lit_dec = lit_reg - 8'd1;

    always_comb
    begin
        phase_pre = phase_reg;
        lit_next  = lit_reg;
        rep_next  = rep_reg;
        hdr_len   = 8'd0;
        run_len   = 8'd1;
        do_run    = 1'b0;
        do_err    = 1'b0;

        if (!s1_valid_reg || phase_reg == PH_DONE || phase_reg == PH_FAILED || empty)
        begin
            phase_pre = phase_reg;
        end
        else if (pos_reg.row >= lim.rows)
        begin
            // Row count was lowered below the current row.
            phase_pre = PH_DONE;
        end
        else if (mode_reg == MODE_RAW)
        begin
            do_err = (room == 8'd0);
            do_run = (room != 8'd0);
        end
        else if (mode_reg != MODE_BYTERUN1)
        begin
            do_err = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_LITERAL:
                begin
                    if (room == 8'd0)
                    begin
                        do_err = 1'b1;
                    end
                    else
                    begin
                        lit_next = lit_dec;
                        if (lit_dec == 8'd0)
                        begin
                            phase_pre = PH_HEADER;
                        end
                        do_run = 1'b1;
                    end
                end
                PH_REPEAT:
                begin
                    phase_pre = PH_HEADER;
                    rep_next  = 8'd0;
                    run_len   = rep_reg;
                    if (rep_reg == 8'd0 || room < rep_reg)
                    begin
                        do_err = 1'b1;
                    end
                    else
                    begin
                        do_run = 1'b1;
                    end
                end
                default:
                begin
                    if (!s1_data_reg[7])
                    begin
                        // Literal header: the next n+1 bytes are copied.
                        hdr_len = s1_data_reg + 8'd1;
                        if (room < hdr_len || s1_last_reg)
                        begin
                            do_err = 1'b1;
                        end
                        else
                        begin
                            lit_next  = hdr_len;
                            phase_pre = PH_LITERAL;
                        end
                    end
                    else if (s1_data_reg == HDR_NOP)
                    begin
                        do_err = s1_last_reg;
                    end
                    else
                    begin
                        // Repeat header: the next byte is written 257-n times.
                        hdr_len = 8'(9'd257 - {1'b0, s1_data_reg});
                        if (room < hdr_len || s1_last_reg)
                        begin
                            do_err = 1'b1;
                        end
                        else
                        begin
                            rep_next  = hdr_len;
                            phase_pre = PH_REPEAT;
                        end
                    end
                end
            endcase
        end
    end

    pbr1_advance u_advance
    (
        .pos      (pos_reg),
        .lim      (lim),
        .len      (run_len),
        .pos_next (adv_pos),
        .done     (adv_done)
    );

    // ------------------------------------------------------------------
    // Result and final state. A run on the last byte that leaves the image
    // unfinished turns into the error beat.
    // ------------------------------------------------------------------
    always_comb
    begin
        res_err    = do_err || (do_run && s1_last_reg && !adv_done);
        res_valid  = res_err || do_run;
        res_done   = do_run && !res_err && adv_done;
        phase_next = phase_pre;
        pos_next   = pos_reg;
        if (res_err)
        begin
            phase_next = PH_FAILED;
        end
        else if (do_run)
        begin
            pos_next = adv_pos;
            if (adv_done)
            begin
                phase_next = PH_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            lit_reg   <= 8'd0;
            rep_reg   <= 8'd0;
            pos_reg   <= '0;
        end
        else if (s1_fire)
        begin
            phase_reg <= phase_next;
            lit_reg   <= lit_next;
            rep_reg   <= rep_next;
            pos_reg   <= pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (s1_fire)
        begin
            out_valid_next = res_valid;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            value_reg <= res_err ? 8'd0 : s1_data_reg;
            len_reg   <= res_err ? 8'd0 : run_len;
            plane_reg <= res_err ? 3'd0 : pos_reg.plane[2:0];
            row_reg   <= res_err ? 10'd0 : pos_reg.row[9:0];
            col_reg   <= res_err ? 7'd0 : pos_reg.col[6:0];
            done_reg  <= res_done;
            err_reg   <= res_err;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign run_length  = len_reg;
    assign plane_index = plane_reg;
    assign row_index   = row_reg;
    assign column      = col_reg;
    assign image_done  = done_reg;
    assign error       = err_reg;

endmodule

`default_nettype wire

// ----- rtl/pbr1_advance.sv -----
// Position stepper: moves the write position by one run and reports image end.
// Depends on pbr1_pkg for pos_t and limits_t.
`default_nettype none

module pbr1_advance
    import pbr1_pkg::*;
(
    input  pos_t             pos,
    input  limits_t          lim,
    input  logic [7:0]       len,
    output pos_t             pos_next,
    output logic             done
);

    logic [BPR_W:0]  col_sum;
    logic            row_end;
    logic [PLN_W:0]  plane_inc;
    logic            plane_wrap;

    always_comb
    begin
        col_sum    = {1'b0, pos.col} + {1'b0, len};
        row_end    = (col_sum >= {1'b0, lim.bpr});
        plane_inc  = {1'b0, pos.plane} + 1'b1;
        plane_wrap = row_end && (plane_inc >= {1'b0, lim.planes});

        pos_next.col = row_end ? '0 : col_sum[BPR_W-1:0];
        if (!row_end)
        begin
            pos_next.plane = pos.plane;
        end
        else if (plane_wrap)
        begin
            pos_next.plane = '0;
        end
        else
        begin
            pos_next.plane = plane_inc[PLN_W-1:0];
        end
        // The row position stays below the row count, so the increment fits.
        pos_next.row = plane_wrap ? pos.row + 1'b1 : pos.row;
        done         = (pos_next.row >= lim.rows);
    end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for planar_byterun1_decoder: directed and random byte streams
// are checked beat by beat against a built-in model of the row, plane and column decode.
// Depends on pbr1_pkg and on the decoder RTL; it needs no other file.

module tb_top
    import pbr1_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Number of random stream bytes to aim for, cycles to let the pipeline drain
    // after the last expected run, and the number of quiet cycles that count as a hang.
    localparam int RAND_ITEMS     = 800;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    // One beat on the input channel.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_beat_t;

    // One beat on the output channel, in port order.
    typedef struct packed {
        logic [7:0] value;
        logic [7:0] run_length;
        logic [2:0] plane;
        logic [9:0] row;
        logic [6:0] column;
        logic       done;
        logic       bad;
    } run_t;

    // Ways in which the single image of the run is brought to its end.
    typedef enum int {
        END_COMPLETE,
        END_SHORT_CHUNK,
        END_ROW_OVERRUN,
        END_BAD_MODE,
        END_LAST_HEADER,
        END_ROWS_CUT
    } ending_t;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             cfg_write = 1'b0;
    logic [1:0]       cfg_index = CFG_COMPRESSION;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    logic [7:0]       data_byte = 8'h00;
    logic             last_byte = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [7:0]       value;
    logic [7:0]       run_length;
    logic [2:0]       plane_index;
    logic [9:0]       row_index;
    logic [6:0]       column;
    logic             image_done;
    logic             error;

    planar_byterun1_decoder u_top (
        .clk,
        .rst_n,
        .cfg_write,
        .cfg_index,
        .cfg_data,
        .in_valid,
        .in_stall,
        .data_byte,
        .last_byte,
        .out_valid,
        .out_stall,
        .value,
        .run_length,
        .plane_index,
        .row_index,
        .column,
        .image_done,
        .error
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Decoder model. It keeps its own copy of the registers and the decode
    // state and is stepped once for every input beat the block accepts.
    // ------------------------------------------------------------------
    logic [MODE_W-1:0] mode_reg   = MODE_RESET;
    logic [BPR_W-1:0]  bpr_reg    = BPR_RESET;
    logic [PLN_W-1:0]  planes_reg = PLN_RESET;
    logic [ROWS_W-1:0] rows_reg   = ROWS_RESET;

    phase_t      dec_phase = PH_HEADER;
    logic [7:0]  lit_left  = '0;
    logic [7:0]  rep_cnt   = '0;
    logic [7:0]  col_pos   = '0;
    logic [3:0]  plane_pos = '0;
    logic [10:0] row_pos   = '0;

    run_t expected_runs[$];

    // Register values as the block uses them, saturated to its build limits.
    function automatic int eff_bpr();
        return (int'(bpr_reg) > MAX_ROW_BYTES_DEF) ? MAX_ROW_BYTES_DEF : int'(bpr_reg);
    endfunction

    function automatic int eff_planes();
        return (int'(planes_reg) > MAX_PLANES_DEF) ? MAX_PLANES_DEF : int'(planes_reg);
    endfunction

    function automatic int eff_rows();
        return (int'(rows_reg) > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_reg);
    endfunction

    // Bytes left before the end of the current row of the current plane. A column
    // already past a shrunken row end leaves no room at all.
    function automatic int room();
        int b;
        b = eff_bpr();
        return (int'(col_pos) >= b) ? 0 : b - int'(col_pos);
    endfunction

    // Moves the write position on by n bytes, wrapping into the next plane and then
    // the next row. Returns 1 when the position has passed the final row.
    function automatic bit step_pos(input int n);
        col_pos = 8'(int'(col_pos) + n);
        if (int'(col_pos) >= eff_bpr())
        begin
            col_pos   = '0;
            plane_pos = plane_pos + 1'b1;
            if (int'(plane_pos) >= eff_planes())
            begin
                plane_pos = '0;
                row_pos   = row_pos + 1'b1;
            end
        end
        return int'(row_pos) >= eff_rows();
    endfunction

    // A malformed stream gives one beat with only the error flag set, and the
    // decoder then drops everything until reset.
    function automatic void push_error();
        run_t r;
        r     = '0;
        r.bad = 1'b1;
        expected_runs.push_back(r);
        dec_phase = PH_FAILED;
    endfunction

    function automatic void push_run(input logic [7:0] val, input int len, input logic lst);
        run_t        r;
        logic [7:0]  c;
        logic [3:0]  p;
        logic [10:0] rw;
        bit          done;
        c    = col_pos;
        p    = plane_pos;
        rw   = row_pos;
        done = step_pos(len);
        // A chunk that ends before the image is complete turns this run into the error.
        if (lst && !done)
        begin
            push_error();
            return;
        end
        r            = '0;
        r.value      = val;
        r.run_length = 8'(len);
        r.plane      = p[2:0];
        r.row        = rw[9:0];
        r.column     = c[6:0];
        r.done       = done;
        expected_runs.push_back(r);
        if (done)
            dec_phase = PH_DONE;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic lst);
        int n;
        if (dec_phase == PH_DONE || dec_phase == PH_FAILED)
            return;
        // With any dimension at zero there is no image, and every byte is dropped.
        if (eff_bpr() == 0 || eff_planes() == 0 || eff_rows() == 0)
            return;
        // The row count was cut below the current row: the image ends silently.
        if (int'(row_pos) >= eff_rows())
        begin
            dec_phase = PH_DONE;
            return;
        end
        if (mode_reg == MODE_RAW)
        begin
            if (room() < 1)
                push_error();
            else
                push_run(b, 1, lst);
            return;
        end
        if (mode_reg != MODE_BYTERUN1)
        begin
            push_error();
            return;
        end
        case (dec_phase)
            PH_LITERAL:
            begin
                if (room() < 1)
                begin
                    push_error();
                    return;
                end
                lit_left = lit_left - 1'b1;
                if (lit_left == 0)
                    dec_phase = PH_HEADER;
                push_run(b, 1, lst);
            end
            PH_REPEAT:
            begin
                n         = int'(rep_cnt);
                dec_phase = PH_HEADER;
                rep_cnt   = '0;
                if (n == 0 || room() < n)
                    push_error();
                else
                    push_run(b, n, lst);
            end
            default:
            begin
                // Header bytes give no beat of their own, but one that is marked as
                // the end of the chunk, or whose run would cross the row end, fails.
                if (b < HDR_NOP)
                begin
                    n = int'(b) + 1;
                    if (room() < n || lst)
                        push_error();
                    else
                    begin
                        lit_left  = 8'(n);
                        dec_phase = PH_LITERAL;
                    end
                end
                else if (b == HDR_NOP)
                begin
                    if (lst)
                        push_error();
                end
                else
                begin
                    n = 257 - int'(b);
                    if (room() < n || lst)
                        push_error();
                    else
                    begin
                        rep_cnt   = 8'(n);
                        dec_phase = PH_REPEAT;
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stream generation. The stimulus process fills this queue; the driver
    // below takes from it. beats_owed counts bytes queued but not yet taken
    // by the block, so the stimulus process can tell when the block is idle.
    // ------------------------------------------------------------------
    in_beat_t    pending_beats[$];
    int unsigned beats_owed    = 0;
    int unsigned items_queued  = 0;
    int unsigned send_idle_pct = 8;
    int unsigned recv_idle_pct = 63;
    int unsigned fail_count    = 0;

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    // Run lengths are mostly short so that headers and row ends come often, with
    // an occasional run over the full allowed span.
    function automatic int pick_len(input int lo, input int hi);
        if ($urandom_range(3) == 0)
            return $urandom_range(lo, hi);
        return $urandom_range(lo, (hi < lo + 3) ? hi : lo + 3);
    endfunction

    function automatic void push_item(input logic [7:0] b, input logic lst);
        in_beat_t beat;
        beat.data = b;
        beat.last = lst;
        pending_beats.push_back(beat);
        beats_owed++;
        items_queued++;
    endfunction

    // Queues a well-formed encoding of exactly n decoded bytes in the current mode,
    // with random literal and repeat runs and a stray no-op header now and then.
    // With mark_last set, the final data byte carries the end-of-chunk flag.
    function automatic void push_fill(input int n, input bit mark_last);
        int lim;
        int len;
        int k;
        while (n > 0)
        begin
            lim = (n > 128) ? 128 : n;
            if (mode_reg == MODE_RAW)
            begin
                len = 1;
                push_item(rand_byte(), mark_last && n == 1);
            end
            else
            begin
                if ($urandom_range(7) == 0)
                    push_item(HDR_NOP, 1'b0);
                if (lim == 1 || $urandom_range(1) == 0)
                begin
                    len = pick_len(1, lim);
                    push_item(8'(len - 1), 1'b0);
                    for (k = 0; k < len; k++)
                        push_item(rand_byte(), mark_last && n == len && k == len - 1);
                end
                else
                begin
                    len = pick_len(2, lim);
                    push_item(8'(257 - len), 1'b0);
                    push_item(rand_byte(), mark_last && n == len);
                end
            end
            n -= len;
        end
    endfunction

    // Register writes go out on consecutive cycles; end_writes drops the enable.
    // The model takes the new value at once, which is safe because writes are
    // only made while the block is idle.
    task automatic write_reg(input cfg_index_t idx, input int val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        case (idx)
            CFG_COMPRESSION:   mode_reg   = 8'(val);
            CFG_BYTES_PER_ROW: bpr_reg    = 8'(val);
            CFG_PLANE_COUNT:   planes_reg = 4'(val);
            default:           rows_reg   = 11'(val);
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Holds the sender back until every queued byte has been taken and every
    // expected run has come out, then lets header bytes still in the pipeline settle.
    task automatic wait_idle();
        while (beats_owed != 0 || expected_runs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Input driver. A beat is taken at an edge where in_valid is high and
    // in_stall is low; the model is stepped right there. A held beat is
    // never changed, and valid is only lowered when the sender idles.
    // ------------------------------------------------------------------
    in_beat_t next_beat;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                decode_byte(data_byte, last_byte);
                beats_owed--;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_beat = pending_beats.pop_front();
                    in_valid  <= 1'b1;
                    data_byte <= next_beat.data;
                    last_byte <= next_beat.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor. Each beat taken from the block is compared with the
    // oldest expected run; the stall is redrawn every cycle.
    // ------------------------------------------------------------------
    run_t seen_run;
    run_t want_run;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen_run = '{value, run_length, plane_index, row_index, column,
                             image_done, error};
                if (expected_runs.size() == 0)
                begin
                    $display("%0t: output beat with no run expected: val=%h len=%0d p=%0d",
                             $time, value, run_length, plane_index);
                    fail_count++;
                end
                else
                begin
                    want_run = expected_runs.pop_front();
                    if (seen_run !== want_run)
                    begin
                        $display("%0t: run mismatch, expected val=%h len=%0d p=%0d r=%0d c=%0d",
                                 $time, want_run.value, want_run.run_length, want_run.plane,
                                 want_run.row, want_run.column);
                        $display("    done=%b err=%b; actual val=%h len=%0d p=%0d r=%0d c=%0d",
                                 want_run.done, want_run.bad, seen_run.value,
                                 seen_run.run_length, seen_run.plane, seen_run.row,
                                 seen_run.column);
                        $display("    done=%b err=%b", seen_run.done, seen_run.bad);
                        fail_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: any beat on either channel or any register write counts as progress.
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[planar_byterun1_decoder] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus. The decoder stops for good once an image is done or has
    // failed, and reset is applied only once, so the whole run decodes one
    // long image: well-formed content under many register settings, with
    // empty-image phases for noise, and a single randomly chosen ending.
    // Every phase change waits for the block to go idle, which also gives
    // the sender the required full pause.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned rand_items;
        int unsigned before_cnt;
        int          segs;
        int          k;
        ending_t     ending;

        rand_items = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed part. The widest rows and the largest plane and row counts first,
        // so that a single repeat can cover a whole 128-byte row.
        write_reg(CFG_COMPRESSION, MODE_BYTERUN1);
        write_reg(CFG_BYTES_PER_ROW, 128);
        write_reg(CFG_PLANE_COUNT, 8);
        write_reg(CFG_ROW_COUNT, 1024);
        end_writes();
        // Plane 0: one repeat of the longest length fills the row.
        push_item(8'd129, 1'b0);
        push_item(8'hFF, 1'b0);
        // Plane 1: shortest repeat, a no-op header, one- and three-byte literals,
        // then a repeat that lands exactly on the row end.
        push_item(8'd255, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(HDR_NOP, 1'b0);
        push_item(8'd0, 1'b0);
        push_item(8'hAA, 1'b0);
        push_item(8'd2, 1'b0);
        push_item(8'h01, 1'b0);
        push_item(8'h80, 1'b0);
        push_item(8'h7F, 1'b0);
        push_item(8'(257 - 122), 1'b0);
        push_item(8'h55, 1'b0);
        wait_idle();

        // Raw mode with two-byte rows, switched mid-image.
        write_reg(CFG_COMPRESSION, MODE_RAW);
        write_reg(CFG_BYTES_PER_ROW, 2);
        end_writes();
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h80, 1'b0);
        push_item(8'h7F, 1'b0);
        wait_idle();

        // Empty image with an unknown compression code: all bytes are dropped,
        // including ones flagged as the end of the chunk.
        write_reg(CFG_COMPRESSION, 255);
        write_reg(CFG_ROW_COUNT, 0);
        end_writes();
        for (k = 0; k < 6; k++)
            push_item((k % 2 == 0) ? 8'h00 : 8'hFF, k % 2 == 0);
        wait_idle();
        write_reg(CFG_ROW_COUNT, 1024);
        end_writes();

        // Random part. The idle mix moves through its three stages as items go out.
        while (rand_items < RAND_ITEMS)
        begin
            wait_idle();
            if (rand_items < RAND_ITEMS / 3)
            begin
                send_idle_pct = 8;
                recv_idle_pct = 63;
            end
            else if (rand_items < 2 * RAND_ITEMS / 3)
            begin
                send_idle_pct = 63;
                recv_idle_pct = 8;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Keep well clear of the last row so the image does not end early.
            if (int'(row_pos) + 12 >= 1000)
                break;
            if ($urandom_range(5) == 0)
            begin
                // Noise into an empty image; these bytes do not count toward the total.
                case ($urandom_range(2))
                    0:       write_reg(CFG_BYTES_PER_ROW, 0);
                    1:       write_reg(CFG_PLANE_COUNT, 0);
                    default: write_reg(CFG_ROW_COUNT, 0);
                endcase
                write_reg(CFG_COMPRESSION, $urandom_range(255));
                end_writes();
                repeat (8) push_item(rand_byte(), 1'($urandom_range(1)));
                wait_idle();
                write_reg(CFG_ROW_COUNT, 1024);
                end_writes();
            end
            else
            begin
                // New geometry mid-image. Phases always end on a row end, so a new
                // row width is safe; a smaller plane count may wrap the plane position.
                write_reg(CFG_COMPRESSION, ($urandom_range(3) == 0) ? MODE_RAW : MODE_BYTERUN1);
                k = $urandom_range(9);
                write_reg(CFG_BYTES_PER_ROW,
                          (k < 6) ? $urandom_range(1, 8) : (k < 9) ? $urandom_range(9, 40) : 128);
                write_reg(CFG_PLANE_COUNT, $urandom_range(1, 8));
                end_writes();
                segs = $urandom_range(1, 10);
                // Trim the last phases so the random total stays close to its target.
                while (segs > 1 && segs * eff_bpr() > int'(RAND_ITEMS - rand_items))
                    segs--;
                before_cnt = items_queued;
                repeat (segs) push_fill(eff_bpr(), 1'b0);
                rand_items += items_queued - before_cnt;
            end
        end

        // Ending: the image completes, or one of the malformed-stream cases ends it.
        wait_idle();
        ending = ending_t'($urandom_range(5));
        write_reg(CFG_COMPRESSION,
                  (ending == END_BAD_MODE) ? $urandom_range(2, 255) : MODE_BYTERUN1);
        write_reg(CFG_BYTES_PER_ROW, $urandom_range(1, 127));
        write_reg(CFG_PLANE_COUNT, $urandom_range(1, 8));
        write_reg(CFG_ROW_COUNT,
                  (ending == END_COMPLETE) ? int'(row_pos) + 1 :
                  (ending == END_ROWS_CUT) ? int'(row_pos) : 1024);
        end_writes();
        case (ending)
            END_COMPLETE:
            begin
                // Finish the current row; the final byte may also close the chunk.
                segs = (int'(plane_pos) < eff_planes()) ? eff_planes() - int'(plane_pos) : 1;
                for (k = 1; k <= segs; k++)
                    push_fill(eff_bpr(), (k == segs) && ($urandom_range(1) == 1));
            end
            END_SHORT_CHUNK:
                push_fill(eff_bpr(), 1'b1);
            END_ROW_OVERRUN:
            begin
                // A run one byte longer than the row, as a literal or as a repeat.
                if ($urandom_range(1) == 0)
                    push_item(8'(eff_bpr()), 1'b0);
                else
                    push_item(8'(257 - (eff_bpr() + 1)), 1'b0);
                push_item(rand_byte(), 1'b0);
            end
            END_LAST_HEADER:
                push_item(rand_byte(), 1'b1);
            default:
                push_item(rand_byte(), 1'b0);
        endcase
        // Whatever follows the end is dropped by the block.
        repeat (16) push_item(rand_byte(), 1'($urandom_range(1)));
        wait_idle();

        if (fail_count == 0)
            $display("[planar_byterun1_decoder] OK");
        else
            $display("[planar_byterun1_decoder] ERROR");
        $finish;
    end

endmodule

// ----- planar_byterun1_decoder.f -----
rtl/pbr1_pkg.sv
rtl/pbr1_advance.sv
rtl/planar_byterun1_decoder.sv
tb/tb_top.sv
